// File: design/obstacle_bypass_sequencer_assert.svh
// assertion macros for the obstacle bypass sequencer checker
`ifndef OBSTACLE_BYPASS_SEQUENCER_ASSERT_SVH
`define OBSTACLE_BYPASS_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define OBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obstacle bypass sequencer check failed");

// next-cycle implication
`define OBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obstacle bypass sequencer check failed");

`endif

// File: design/obs_pkg.sv
// shared types and constants for the obstacle bypass sequencer
`default_nettype none
package obs_pkg;

   typedef enum logic [3:0] {
      PH_CLEAR     = 4'd0,
      PH_WAIT      = 4'd1,
      PH_RECHECK   = 4'd2,
      PH_SELECT    = 4'd3,
      PH_SPIN      = 4'd4,
      PH_FORWARD   = 4'd5,
      PH_COUNTER   = 4'd6,
      PH_RESUME    = 4'd7,
      PH_EMERGENCY = 4'd8
   } phase_type;

   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [2:0] REG_CRUISE_SPEED  = 3'd0;
   localparam logic [2:0] REG_TURN_SPEED    = 3'd1;
   localparam logic [2:0] REG_WAIT_TIME     = 3'd2;
   localparam logic [2:0] REG_TURN_TIME     = 3'd3;
   localparam logic [2:0] REG_SIDESTEP_TIME = 3'd4;
   localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd5;

   localparam logic [14:0] CRUISE_SPEED_RST  = 15'd16384;
   localparam logic [14:0] TURN_SPEED_RST    = 15'd16384;
   localparam logic [15:0] WAIT_TIME_RST     = 16'd1000;
   localparam logic [15:0] TURN_TIME_RST     = 16'd500;
   localparam logic [15:0] SIDESTEP_TIME_RST = 16'd1000;
   localparam logic [7:0]  ATTEMPT_LIMIT_RST = 8'd3;

   typedef struct packed {
      logic [14:0] cruise_speed;
      logic [14:0] turn_speed;
      logic [15:0] wait_time_ms;
      logic [15:0] turn_time_ms;
      logic [15:0] sidestep_time_ms;
      logic [7:0]  attempt_limit;
   } cfg_type;

   typedef struct packed {
      logic        blocked_ahead;
      logic        blocked_left;
      logic        blocked_right;
      logic [15:0] tick_ms;
   } item_type;

   typedef struct packed {
      logic signed [15:0] left_drive;
      logic signed [15:0] right_drive;
      logic               emergency;
      logic [3:0]         phase_now;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] phase_time;
      logic [7:0]  attempts_used;
      logic        turn_right;
   } state_type;

endpackage
`default_nettype wire

// File: design/obs_req_if.sv
// input channel interface carrying one sensor tick per beat
`default_nettype none
interface obs_req_if;
   logic        valid;
   logic        ready;
   logic        blocked_ahead;
   logic        blocked_left;
   logic        blocked_right;
   logic [15:0] tick_ms;

   modport source (output valid, blocked_ahead, blocked_left, blocked_right, tick_ms,
                   input ready);
   modport sink (input valid, blocked_ahead, blocked_left, blocked_right, tick_ms,
                 output ready);
endinterface
`default_nettype wire

// File: design/obs_rsp_if.sv
// result channel interface carrying one drive command per beat
`default_nettype none
interface obs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_drive;
   logic signed [15:0] right_drive;
   logic               emergency;
   logic [3:0]         phase_now;

   modport source (output valid, left_drive, right_drive, emergency, phase_now,
                   input ready);
   modport sink (input valid, left_drive, right_drive, emergency, phase_now,
                 output ready);
endinterface
`default_nettype wire

// File: design/obs_csr.sv
// apb configuration registers of the obstacle bypass sequencer
`default_nettype none
module obs_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [obs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output obs_pkg::cfg_type                     cfg
);
   import obs_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise_speed     <= CRUISE_SPEED_RST;
         cfg_ff.turn_speed       <= TURN_SPEED_RST;
         cfg_ff.wait_time_ms     <= WAIT_TIME_RST;
         cfg_ff.turn_time_ms     <= TURN_TIME_RST;
         cfg_ff.sidestep_time_ms <= SIDESTEP_TIME_RST;
         cfg_ff.attempt_limit    <= ATTEMPT_LIMIT_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_CRUISE_SPEED:  cfg_ff.cruise_speed     <= pwdata[14:0];
            REG_TURN_SPEED:    cfg_ff.turn_speed       <= pwdata[14:0];
            REG_WAIT_TIME:     cfg_ff.wait_time_ms     <= pwdata[15:0];
            REG_TURN_TIME:     cfg_ff.turn_time_ms     <= pwdata[15:0];
            REG_SIDESTEP_TIME: cfg_ff.sidestep_time_ms <= pwdata[15:0];
            REG_ATTEMPT_LIMIT: cfg_ff.attempt_limit    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CRUISE_SPEED:  prdata = {17'd0, cfg_ff.cruise_speed};
         REG_TURN_SPEED:    prdata = {17'd0, cfg_ff.turn_speed};
         REG_WAIT_TIME:     prdata = {16'd0, cfg_ff.wait_time_ms};
         REG_TURN_TIME:     prdata = {16'd0, cfg_ff.turn_time_ms};
         REG_SIDESTEP_TIME: prdata = {16'd0, cfg_ff.sidestep_time_ms};
         REG_ATTEMPT_LIMIT: prdata = {24'd0, cfg_ff.attempt_limit};
         default:           prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

// File: design/obs_next.sv
// per-tick phase transition and drive computation
`default_nettype none
module obs_next (
   input  wire obs_pkg::state_type  cur_state,
   input  wire obs_pkg::item_type   item,
   input  wire obs_pkg::cfg_type    cfg,
   output obs_pkg::state_type       nxt_state,
   output obs_pkg::result_type      result
);
   import obs_pkg::*;

   logic [32:0] sum_w;
   logic [31:0] pt_sum;
   logic [15:0] fwd;
   logic [15:0] turn_pos;
   logic [15:0] turn_neg;
   logic        both_sides;
   logic        sel_right;
   logic [7:0]  att_inc;

   assign sum_w      = {1'b0, cur_state.phase_time} + {17'd0, item.tick_ms};
   assign pt_sum     = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
   assign fwd        = {1'b0, cfg.cruise_speed};
   assign turn_pos   = {1'b0, cfg.turn_speed};
   assign turn_neg   = 16'd0 - turn_pos;
   assign both_sides = item.blocked_left && item.blocked_right;
   assign sel_right  = item.blocked_left && !item.blocked_right;
   assign att_inc    = (cur_state.attempts_used == 8'hFF) ? 8'hFF
                                                          : cur_state.attempts_used + 8'd1;

   always_comb begin
      nxt_state            = cur_state;
      nxt_state.phase_time = pt_sum;
      result.left_drive    = 16'sd0;
      result.right_drive   = 16'sd0;
      result.emergency     = 1'b0;

      case (cur_state.phase)
         PH_CLEAR: begin
            if (item.blocked_ahead) begin
               nxt_state.phase      = PH_WAIT;
               nxt_state.phase_time = 32'd0;
            end else begin
               result.left_drive  = fwd;
               result.right_drive = fwd;
            end
         end
         PH_WAIT: begin
            if (pt_sum >= {16'd0, cfg.wait_time_ms}) begin
               nxt_state.phase      = PH_RECHECK;
               nxt_state.phase_time = 32'd0;
            end
         end
         PH_RECHECK: begin
            nxt_state.phase_time = 32'd0;
            if (!item.blocked_ahead) begin
               nxt_state.phase    = PH_RESUME;
               result.left_drive  = fwd;
               result.right_drive = fwd;
            end else if (both_sides || cur_state.attempts_used >= cfg.attempt_limit) begin
               nxt_state.phase  = PH_EMERGENCY;
               result.emergency = 1'b1;
            end else begin
               nxt_state.phase         = PH_SPIN;
               nxt_state.turn_right    = sel_right;
               nxt_state.attempts_used = att_inc;
               result.left_drive       = sel_right ? turn_pos : turn_neg;
               result.right_drive      = sel_right ? turn_neg : turn_pos;
            end
         end
         PH_SELECT: begin
            nxt_state.phase_time    = 32'd0;
            nxt_state.phase         = PH_SPIN;
            nxt_state.turn_right    = sel_right;
            nxt_state.attempts_used = att_inc;
            result.left_drive       = sel_right ? turn_pos : turn_neg;
            result.right_drive      = sel_right ? turn_neg : turn_pos;
         end
         PH_SPIN: begin
            if (both_sides) begin
               nxt_state.phase      = PH_EMERGENCY;
               nxt_state.phase_time = 32'd0;
               result.emergency     = 1'b1;
            end else if (pt_sum >= {16'd0, cfg.turn_time_ms}) begin
               nxt_state.phase      = PH_FORWARD;
               nxt_state.phase_time = 32'd0;
               result.left_drive    = fwd;
               result.right_drive   = fwd;
            end else begin
               result.left_drive  = cur_state.turn_right ? turn_pos : turn_neg;
               result.right_drive = cur_state.turn_right ? turn_neg : turn_pos;
            end
         end
         PH_FORWARD: begin
            if (both_sides) begin
               nxt_state.phase      = PH_EMERGENCY;
               nxt_state.phase_time = 32'd0;
               result.emergency     = 1'b1;
            end else if (pt_sum >= {16'd0, cfg.sidestep_time_ms}) begin
               nxt_state.phase      = PH_COUNTER;
               nxt_state.phase_time = 32'd0;
               result.left_drive    = cur_state.turn_right ? turn_neg : turn_pos;
               result.right_drive   = cur_state.turn_right ? turn_pos : turn_neg;
            end else begin
               result.left_drive  = fwd;
               result.right_drive = fwd;
            end
         end
         PH_COUNTER: begin
            if (pt_sum >= {16'd0, cfg.turn_time_ms}) begin
               nxt_state.phase      = PH_RESUME;
               nxt_state.phase_time = 32'd0;
               result.left_drive    = fwd;
               result.right_drive   = fwd;
            end else begin
               result.left_drive  = cur_state.turn_right ? turn_neg : turn_pos;
               result.right_drive = cur_state.turn_right ? turn_pos : turn_neg;
            end
         end
         PH_RESUME: begin
            nxt_state.phase      = PH_CLEAR;
            nxt_state.phase_time = 32'd0;
            result.left_drive    = fwd;
            result.right_drive   = fwd;
         end
         PH_EMERGENCY: begin
            result.emergency = 1'b1;
         end
         default: ;
      endcase

      result.phase_now = nxt_state.phase;
   end
endmodule
`default_nettype wire

// File: design/obs_pipe.sv
// input register, sequencer state and result register with handshakes
`default_nettype none
module obs_pipe (
   input  wire logic                  clock,
   input  wire logic                  reset,
   obs_req_if.sink                    req_bus,
   obs_rsp_if.source                  rsp_bus,
   output obs_pkg::item_type          item,
   output obs_pkg::state_type         cur_state,
   input  wire obs_pkg::state_type    state_in,
   input  wire obs_pkg::result_type   rsp_in
);
   import obs_pkg::*;

   item_type   item_ff;
   logic       item_valid_ff;
   state_type  state_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_take;

   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !item_valid_ff || advance;
   assign req_take       = req_bus.valid && req_bus.ready;

   assign item      = item_ff;
   assign cur_state = state_ff;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_drive  = rsp_ff.left_drive;
   assign rsp_bus.right_drive = rsp_ff.right_drive;
   assign rsp_bus.emergency   = rsp_ff.emergency;
   assign rsp_bus.phase_now   = rsp_ff.phase_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff          <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.phase         <= PH_CLEAR;
         state_ff.phase_time    <= 32'd0;
         state_ff.attempts_used <= 8'd0;
         state_ff.turn_right    <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            item_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.blocked_ahead <= req_bus.blocked_ahead;
         item_ff.blocked_left  <= req_bus.blocked_left;
         item_ff.blocked_right <= req_bus.blocked_right;
         item_ff.tick_ms       <= req_bus.tick_ms;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end
endmodule
`default_nettype wire

// File: design/obstacle_bypass_sequencer.sv
// Obstacle bypass sequencer: one tick in on req_bus, one drive command out on rsp_bus.
// Each req beat carries the ahead/left/right obstacle flags and the milliseconds since
// the previous tick; each rsp beat carries the left and right wheel drives (Q1.15),
// the emergency flag and the phase after the tick. Exactly one rsp beat per req beat,
// in order.
// A beat is registered on entry in the input register, the phase logic works on it
// combinationally and the result lands in the output register, from which it is
// offered on rsp_bus. One beat per cycle is sustained while rsp_bus.ready stays high;
// the phase state register is updated each cycle that a tick moves into the output
// register.
// When rsp_bus.ready is low the output register holds its beat and one more tick can
// sit in the input register; req_bus.ready drops only when both are full.
// Reset: phase clear, elapsed time and attempt count zero, spin direction left, both
// registers empty; the apb registers return to their reset values (cruise and turn
// speed 16384, wait 1000 ms, turn 500 ms, sidestep 1000 ms, three attempts).
// Registers sit at byte address 4*i; the user must write them only while the block is
// idle, which the block itself does not enforce. An emergency stop holds until reset.
`default_nettype none
module obstacle_bypass_sequencer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   obs_req_if.sink                              req_bus,
   obs_rsp_if.source                            rsp_bus,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [obs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import obs_pkg::*;

   cfg_type    cfg;
   item_type   item;
   state_type  cur_state;
   state_type  state_in;
   result_type rsp_in;

   obs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   obs_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .item      (item),
      .cur_state (cur_state),
      .state_in  (state_in),
      .rsp_in    (rsp_in)
   );

   obs_next u_next (
      .cur_state (cur_state),
      .item      (item),
      .cfg       (cfg),
      .nxt_state (state_in),
      .result    (rsp_in)
   );
endmodule
`default_nettype wire

// File: design/obs_checker.sv
// port-level checks for the obstacle bypass sequencer and their bind
`default_nettype none
`include "obstacle_bypass_sequencer_assert.svh"
module obs_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [15:0] left_drive,
   input  wire logic signed [15:0] right_drive,
   input  wire logic               emergency,
   input  wire logic [3:0]         phase_now
);
   import obs_pkg::*;

   logic seen_emerg_ff;
   logic rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_emerg_ff <= 1'b0;
      end else if (rsp_beat && emergency) begin
         seen_emerg_ff <= 1'b1;
      end
   end

   // stalled result holds
   `OBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({left_drive, right_drive, emergency, phase_now}))

   // emergency flag matches the emergency phase and stops the wheels
   `OBS_ASSERT_NOW(a_emerg_phase, clock, reset, rsp_valid, (emergency == (phase_now == PH_EMERGENCY)) && (!emergency || (left_drive == 16'sd0 && right_drive == 16'sd0)))

   // select runs in the recheck tick and is never reported
   `OBS_ASSERT_NOW(a_no_select, clock, reset, rsp_valid, phase_now != PH_SELECT && phase_now <= PH_EMERGENCY)

   // emergency latches until reset
   `OBS_ASSERT_NOW(a_emerg_latch, clock, reset, rsp_valid && seen_emerg_ff, emergency)
endmodule

bind obstacle_bypass_sequencer obs_checker u_obs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .left_drive  (rsp_bus.left_drive),
   .right_drive (rsp_bus.right_drive),
   .emergency   (rsp_bus.emergency),
   .phase_now   (rsp_bus.phase_now)
);
`default_nettype wire
